### rtl/hyq_pkg.sv
// Shared types, constants and the arctangent table for the heading-to-yaw pipeline.
package hyq_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned MAX_STAGES        = 32;

  // vectoring datapath: 33-bit differences plus CORDIC growth (< 2.4x)
  localparam int unsigned VEC_W  = 36;
  // rotation datapath: Q4.30 magnitudes and the residual angle
  localparam int unsigned ROT_W  = 34;
  localparam int unsigned ROT_ZW = 34;

  // 0.60725 in Q4.30, the CORDIC gain compensation
  localparam logic signed [ROT_W-1:0] CORDIC_K = 34'sd652032874;

  // forced-angle codes for the axis-aligned cases, in quarter turns
  typedef enum logic [1:0] {
    QUAD_ZERO  = 2'd0,
    QUAD_HALF  = 2'd1,
    QUAD_ONE   = 2'd2,
    QUAD_THREE = 2'd3
  } quad_e;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
  } pos_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic [31:0]             z;     // turn fraction, 2^32 = one turn
    logic                    spec;  // axis-aligned or zero vector
    logic [1:0]              quad;  // forced angle in quarter turns
  } vec_t;

  typedef struct packed {
    logic signed [ROT_W-1:0]  x;
    logic signed [ROT_W-1:0]  y;
    logic signed [ROT_ZW-1:0] z;
    logic                     upper;  // quarter turn removed from half angle
    logic [15:0]              yaw;
  } rot_t;

  // atan(2^-i) as a fraction of a full turn, truncated
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051D;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2E;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000002;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

### rtl/hyq_vec_stage.sv
// One vectoring CORDIC iteration with its pipeline register.
module hyq_vec_stage #(
  parameter int unsigned STAGE = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hyq_pkg::vec_t in_data_i,
  input  hyq_pkg::pos_t in_pos_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hyq_pkg::vec_t out_data_o,
  output hyq_pkg::pos_t out_pos_o
);
  import hyq_pkg::*;

  localparam logic [4:0]  Idx  = 5'(STAGE);
  localparam logic [31:0] Atan = atan_turn(Idx);

  logic signed [VEC_W-1:0] xs, ys;
  vec_t data_d, data_q;
  pos_t pos_q;
  logic valid_q;

  always_comb begin
    xs = in_data_i.x >>> STAGE;
    ys = in_data_i.y >>> STAGE;
    data_d = in_data_i;
    if (!in_data_i.y[VEC_W-1] && (in_data_i.y != '0)) begin
      data_d.x = in_data_i.x + ys;
      data_d.y = in_data_i.y - xs;
      data_d.z = in_data_i.z + Atan;
    end else begin
      data_d.x = in_data_i.x - ys;
      data_d.y = in_data_i.y + xs;
      data_d.z = in_data_i.z - Atan;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
      pos_q  <= in_pos_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_pos_o   = pos_q;

endmodule

### rtl/hyq_rot_stage.sv
// One rotation CORDIC iteration with its pipeline register.
module hyq_rot_stage #(
  parameter int unsigned STAGE = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hyq_pkg::rot_t in_data_i,
  input  hyq_pkg::pos_t in_pos_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hyq_pkg::rot_t out_data_o,
  output hyq_pkg::pos_t out_pos_o
);
  import hyq_pkg::*;

  localparam logic [4:0] Idx = 5'(STAGE);
  localparam logic signed [ROT_ZW-1:0] Atan = $signed({{(ROT_ZW-32){1'b0}}, atan_turn(Idx)});

  logic signed [ROT_W-1:0] xs, ys;
  rot_t data_d, data_q;
  pos_t pos_q;
  logic valid_q;

  always_comb begin
    xs = in_data_i.x >>> STAGE;
    ys = in_data_i.y >>> STAGE;
    data_d = in_data_i;
    if (!in_data_i.z[ROT_ZW-1]) begin
      data_d.x = in_data_i.x - ys;
      data_d.y = in_data_i.y + xs;
      data_d.z = in_data_i.z - Atan;
    end else begin
      data_d.x = in_data_i.x + ys;
      data_d.y = in_data_i.y - xs;
      data_d.z = in_data_i.z + Atan;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
      pos_q  <= in_pos_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_pos_o   = pos_q;

endmodule

### rtl/heading_to_yaw_quaternion_core.sv
// Top level: heading vector to yaw angle and yaw-only quaternion, fully pipelined.
//
// Input channel: in_valid_i / in_stall_o carry one beat of center point and axis
// point (Q16.16). Output channel: out_valid_o / out_stall_i carry the center
// passed through, the yaw as a turn fraction and quat_z/quat_w in Q1.15.
// Every input beat gives exactly one output beat, in order.
//
// Pipeline: difference stage, setup stage (axis cases, left half plane fold),
// N vectoring CORDIC stages, yaw rounding stage, N rotation CORDIC stages and
// the output stage (rounding, quadrant swap, saturation).
// N = min(CORDIC_STAGES, 32). With the output free, throughput is one beat per
// cycle, set by one add/sub per stage.
//
// Each stage has its own valid bit and takes a beat when empty or when its
// successor takes. A stall at the output holds the last beat and lets bubbles
// further up close, so the input stalls only once every stage is full.
// Reset clears all valid bits; payload registers are not reset.
module heading_to_yaw_quaternion_core #(
  parameter int unsigned CORDIC_STAGES = hyq_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  input  logic signed [31:0] axis_point_x_i,
  input  logic signed [31:0] axis_point_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic [15:0]        yaw_angle_o,
  output logic signed [15:0] quat_z_o,
  output logic signed [15:0] quat_w_o
);
  import hyq_pkg::*;

  localparam int unsigned NStg =
    (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

  localparam logic signed [ROT_W-1:0] SatHi = 32767;
  localparam logic signed [ROT_W-1:0] SatLo = -32768;
  localparam logic signed [ROT_W-1:0] RndQ15 = 16384;

  function automatic logic signed [15:0] sat16(input logic signed [ROT_W-1:0] v);
    logic signed [15:0] r;
    if (v > SatHi) begin
      r = 16'sh7FFF;
    end else if (v < SatLo) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // ---------------- difference stage ----------------
  logic               a_valid_q, a_ready;
  logic signed [32:0] a_dx_q, a_dy_q;
  pos_t               a_pos_q;
  logic               b_ready;

  assign a_ready    = !a_valid_q || b_ready;
  assign in_stall_o = !a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && a_ready) begin
      a_dx_q  <= $signed({axis_point_x_i[31], axis_point_x_i})
               - $signed({center_x_i[31], center_x_i});
      a_dy_q  <= $signed({axis_point_y_i[31], axis_point_y_i})
               - $signed({center_y_i[31], center_y_i});
      a_pos_q <= '{cx: center_x_i, cy: center_y_i, cz: center_z_i};
    end
  end

  // ---------------- vectoring chain ----------------
  vec_t vec_data  [NStg+1];
  pos_t vec_pos   [NStg+1];
  logic vec_valid [NStg+1];
  logic vec_ready [NStg+1];

  // setup stage: axis cases and fold of the left half plane
  logic signed [VEC_W-1:0] b_dx, b_dy;
  logic                    b_dx_zero, b_dy_zero, b_dx_neg, b_dy_neg;
  vec_t                    b_data_d, b_data_q;
  pos_t                    b_pos_q;
  logic                    b_valid_q;

  always_comb begin
    b_dx      = {{(VEC_W-33){a_dx_q[32]}}, a_dx_q};
    b_dy      = {{(VEC_W-33){a_dy_q[32]}}, a_dy_q};
    b_dx_zero = (a_dx_q == '0);
    b_dy_zero = (a_dy_q == '0);
    b_dx_neg  = a_dx_q[32];
    b_dy_neg  = a_dy_q[32];
    b_data_d.spec = b_dx_zero || b_dy_zero;
    if (b_dx_zero && b_dy_zero) begin
      b_data_d.quad = QUAD_ZERO;
    end else if (b_dy_zero) begin
      b_data_d.quad = b_dx_neg ? QUAD_ONE : QUAD_ZERO;
    end else begin
      b_data_d.quad = b_dy_neg ? QUAD_THREE : QUAD_HALF;
    end
    if (b_dx_neg) begin
      b_data_d.x = -b_dx;
      b_data_d.y = -b_dy;
      b_data_d.z = 32'h80000000;
    end else begin
      b_data_d.x = b_dx;
      b_data_d.y = b_dy;
      b_data_d.z = 32'h0;
    end
  end

  assign b_ready = !b_valid_q || vec_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && b_ready) begin
      b_data_q <= b_data_d;
      b_pos_q  <= a_pos_q;
    end
  end

  assign vec_valid[0] = b_valid_q;
  assign vec_data[0]  = b_data_q;
  assign vec_pos[0]   = b_pos_q;

  for (genvar k = 0; k < NStg; k++) begin : g_vec
    hyq_vec_stage #(
      .STAGE(k)
    ) u_vec (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (vec_valid[k]),
      .in_ready_o  (vec_ready[k]),
      .in_data_i   (vec_data[k]),
      .in_pos_i    (vec_pos[k]),
      .out_valid_o (vec_valid[k+1]),
      .out_ready_i (vec_ready[k+1]),
      .out_data_o  (vec_data[k+1]),
      .out_pos_o   (vec_pos[k+1])
    );
  end

  // ---------------- yaw rounding stage ----------------
  rot_t rot_data  [NStg+1];
  pos_t rot_pos   [NStg+1];
  logic rot_valid [NStg+1];
  logic rot_ready [NStg+1];

  logic [31:0] f_ang, f_rnd;
  rot_t        f_data_d, f_data_q;
  pos_t        f_pos_q;
  logic        f_valid_q;

  always_comb begin
    f_ang = vec_data[NStg].spec ? {vec_data[NStg].quad, 30'b0} : vec_data[NStg].z;
    f_rnd = f_ang + 32'h8000;
    f_data_d.yaw   = f_rnd[31:16];
    // half angle is yaw << 15; a set top bit means a quarter turn comes off
    f_data_d.upper = f_rnd[31];
    f_data_d.z     = $signed({{(ROT_ZW-30){1'b0}}, f_rnd[30:16], 15'b0});
    f_data_d.x     = CORDIC_K;
    f_data_d.y     = '0;
  end

  assign vec_ready[NStg] = !f_valid_q || rot_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (vec_ready[NStg]) begin
      f_valid_q <= vec_valid[NStg];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vec_valid[NStg] && vec_ready[NStg]) begin
      f_data_q <= f_data_d;
      f_pos_q  <= vec_pos[NStg];
    end
  end

  assign rot_valid[0] = f_valid_q;
  assign rot_data[0]  = f_data_q;
  assign rot_pos[0]   = f_pos_q;

  // ---------------- rotation chain ----------------
  for (genvar k = 0; k < NStg; k++) begin : g_rot
    hyq_rot_stage #(
      .STAGE(k)
    ) u_rot (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (rot_valid[k]),
      .in_ready_o  (rot_ready[k]),
      .in_data_i   (rot_data[k]),
      .in_pos_i    (rot_pos[k]),
      .out_valid_o (rot_valid[k+1]),
      .out_ready_i (rot_ready[k+1]),
      .out_data_o  (rot_data[k+1]),
      .out_pos_o   (rot_pos[k+1])
    );
  end

  // ---------------- output stage ----------------
  logic signed [ROT_W-1:0] o_cs_r, o_sn_r, o_cs, o_sn, o_qz, o_qw;
  logic                    o_valid_q;
  pos_t                    o_pos_q;
  logic [15:0]             o_yaw_q;
  logic signed [15:0]      o_qz_q, o_qw_q;

  always_comb begin
    o_cs_r = rot_data[NStg].x + RndQ15;
    o_sn_r = rot_data[NStg].y + RndQ15;
    o_cs   = o_cs_r >>> 15;
    o_sn   = o_sn_r >>> 15;
    if (rot_data[NStg].upper) begin
      o_qz = o_cs;
      o_qw = -o_sn;
    end else begin
      o_qz = o_sn;
      o_qw = o_cs;
    end
  end

  assign rot_ready[NStg] = !o_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (rot_ready[NStg]) begin
      o_valid_q <= rot_valid[NStg];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rot_valid[NStg] && rot_ready[NStg]) begin
      o_pos_q <= rot_pos[NStg];
      o_yaw_q <= rot_data[NStg].yaw;
      o_qz_q  <= sat16(o_qz);
      o_qw_q  <= sat16(o_qw);
    end
  end

  assign out_valid_o = o_valid_q;
  assign pos_x_o     = o_pos_q.cx;
  assign pos_y_o     = o_pos_q.cy;
  assign pos_z_o     = o_pos_q.cz;
  assign yaw_angle_o = o_yaw_q;
  assign quat_z_o    = o_qz_q;
  assign quat_w_o    = o_qw_q;

`ifndef NO_ASSERTIONS
  // input stalls only behind a held beat in the first stage
  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> a_valid_q)
    else $error("input stalled while difference stage empty");

  // after the fold, a general-case vector lies in the right half plane
  a_fold_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vec_valid[0] && !vec_data[0].spec) |-> (vec_data[0].x > 0))
    else $error("setup stage left a general vector with x <= 0");

  // a beat held in the rounding stage neither drops nor changes
  a_round_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_valid_q && !rot_ready[0]) |=> (f_valid_q && $stable(f_data_q)))
    else $error("rounding stage lost or changed a held beat");
`endif

endmodule
